// ===== design/rycc_pkg.sv =====
// ----------------------------------------------------------------------------
// rycc_pkg
// shared types and constants for the rgb / ycbcr color converter pipeline
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package rycc_pkg;

    // number of color channels and width of one signed multiplier operand
    localparam int NCH = 3;
    localparam int OPW = 11;

    // direction select codes
    localparam logic FUNC_RGB2YUV = 1'b0;
    localparam logic FUNC_YUV2RGB = 1'b1;

    // channel indexes
    localparam int CH_0 = 0;
    localparam int CH_1 = 1;
    localparam int CH_2 = 2;

    // chroma offset
    localparam int CHROMA_OFS = 128;

    // saturation limits
    localparam int SAT_HI_8 = 255;
    localparam int SAT_HI_9 = 511;

    typedef struct packed {
        logic       func;
        logic [7:0] comp0;
        logic [8:0] comp1;
        logic [8:0] comp2;
    } t_pix_in;

    typedef struct packed {
        logic [7:0] out0;
        logic [8:0] out1;
        logic [8:0] out2;
        logic       in_gamut;
    } t_pix_out;

    // control that travels alongside each pipeline stage
    typedef struct packed {
        logic valid;
        logic func;
    } t_ctl;

endpackage

// ===== design/rgb_yuv_color_converter_top.sv =====
// ----------------------------------------------------------------------------
// rgb_yuv_color_converter_top
// full-range rgb <-> ycbcr converter, one pixel per transaction
//
// input channel: i_valid / o_stall with payload i_data (func, comp0..comp2);
// func selects rgb to ycbcr (0) or ycbcr to rgb (1)
// output channel: o_valid / i_stall with payload o_data (out0..out2, in_gamut)
// five register stages: input/operand, products, sums, truncation, clamp/output
// throughput is one transaction per clock unless i_stall holds the output;
// nine coefficient multipliers, one per product, form all the products in a single stage
// when the output is held by i_stall the whole pipeline freezes and o_stall
// goes high in the same cycle, nothing is dropped or duplicated
// synchronous active-low reset clears every stage valid bit, pipeline empty
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rgb_yuv_color_converter_top #(
    parameter int COEF_FRAC_BITS = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  rycc_pkg::t_pix_in   i_data,
    output logic                o_valid,
    input  logic                i_stall,
    output rycc_pkg::t_pix_out  o_data
);

    localparam int PW = COEF_FRAC_BITS + 3 + rycc_pkg::OPW;
    localparam int SW = PW + 2;

    logic                 en;
    rycc_pkg::t_ctl       mul_ctl;
    rycc_pkg::t_ctl       sum_ctl;
    logic signed [PW-1:0] prod [rycc_pkg::NCH][rycc_pkg::NCH];
    logic signed [SW-1:0] sum  [rycc_pkg::NCH];

    // pipeline moves unless a finished result is being held
    assign en      = !(o_valid && i_stall);
    assign o_stall = !en;

    rycc_mul #(
        .COEF_FRAC_BITS(COEF_FRAC_BITS)
    ) u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (i_valid),
        .i_data  (i_data),
        .o_ctl   (mul_ctl),
        .o_prod  (prod)
    );

    rycc_sum #(
        .COEF_FRAC_BITS(COEF_FRAC_BITS)
    ) u_sum (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_ctl   (mul_ctl),
        .i_prod  (prod),
        .o_ctl   (sum_ctl),
        .o_sum   (sum)
    );

    rycc_fin #(
        .COEF_FRAC_BITS(COEF_FRAC_BITS)
    ) u_fin (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_ctl   (sum_ctl),
        .i_sum   (sum),
        .o_valid (o_valid),
        .o_data  (o_data)
    );

endmodule

// ===== design/rycc_mul.sv =====
// ----------------------------------------------------------------------------
// rycc_mul
// input register, operand preparation and the nine coefficient products
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rycc_mul #(
    parameter int COEF_FRAC_BITS = 16
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_en,
    input  logic                      i_valid,
    input  rycc_pkg::t_pix_in         i_data,
    output rycc_pkg::t_ctl            o_ctl,
    output logic signed [COEF_FRAC_BITS+3+rycc_pkg::OPW-1:0]
                                      o_prod [rycc_pkg::NCH][rycc_pkg::NCH]
);

    localparam int CW = COEF_FRAC_BITS + 3;
    localparam int PW = CW + rycc_pkg::OPW;

    localparam longint ONE  = longint'(1) << COEF_FRAC_BITS;
    localparam longint K_YR = (299 * ONE + 500) / 1000;
    localparam longint K_YG = (587 * ONE + 500) / 1000;
    localparam longint K_YB = (114 * ONE + 500) / 1000;
    localparam longint K_UR = (1687 * ONE + 5000) / 10000;
    localparam longint K_UG = (3313 * ONE + 5000) / 10000;
    localparam longint K_HF = (ONE + 1) / 2;
    localparam longint K_VG = (4187 * ONE + 5000) / 10000;
    localparam longint K_VB = (813 * ONE + 5000) / 10000;
    localparam longint K_RV = (1402 * ONE + 500) / 1000;
    localparam longint K_GU = (34414 * ONE + 50000) / 100000;
    localparam longint K_GV = (71414 * ONE + 50000) / 100000;
    localparam longint K_BU = (1772 * ONE + 500) / 1000;

    // rows are output channels, columns the three operands
    localparam logic signed [CW-1:0] C_FWD [rycc_pkg::NCH][rycc_pkg::NCH] = '{
        '{CW'(K_YR),  CW'(K_YG),  CW'(K_YB)},
        '{CW'(-K_UR), CW'(-K_UG), CW'(K_HF)},
        '{CW'(K_HF),  CW'(-K_VG), CW'(-K_VB)}
    };
    localparam logic signed [CW-1:0] C_INV [rycc_pkg::NCH][rycc_pkg::NCH] = '{
        '{CW'(ONE), CW'(0),     CW'(K_RV)},
        '{CW'(ONE), CW'(-K_GU), CW'(-K_GV)},
        '{CW'(ONE), CW'(K_BU),  CW'(0)}
    };

    rycc_pkg::t_ctl r_s1_ctl;
    rycc_pkg::t_ctl r_s2_ctl;
    logic signed [rycc_pkg::OPW-1:0] r_op   [rycc_pkg::NCH];
    logic signed [rycc_pkg::OPW-1:0] n_op   [rycc_pkg::NCH];
    logic signed [PW-1:0]            r_prod [rycc_pkg::NCH][rycc_pkg::NCH];
    logic signed [PW-1:0]            n_prod [rycc_pkg::NCH][rycc_pkg::NCH];

    // inverse direction works on chroma with the offset removed
    always_comb begin
        n_op[rycc_pkg::CH_0] = $signed({3'b000, i_data.comp0});
        if (i_data.func == rycc_pkg::FUNC_YUV2RGB) begin
            n_op[rycc_pkg::CH_1] = $signed({2'b00, i_data.comp1})
                                   - rycc_pkg::OPW'(rycc_pkg::CHROMA_OFS);
            n_op[rycc_pkg::CH_2] = $signed({2'b00, i_data.comp2})
                                   - rycc_pkg::OPW'(rycc_pkg::CHROMA_OFS);
        end else begin
            n_op[rycc_pkg::CH_1] = $signed({2'b00, i_data.comp1});
            n_op[rycc_pkg::CH_2] = $signed({2'b00, i_data.comp2});
        end
    end

    always_comb begin
        for (int ch = 0; ch < rycc_pkg::NCH; ch++) begin
            for (int k = 0; k < rycc_pkg::NCH; k++) begin
                if (r_s1_ctl.func == rycc_pkg::FUNC_YUV2RGB) begin
                    n_prod[ch][k] = C_INV[ch][k] * r_op[k];
                end else begin
                    n_prod[ch][k] = C_FWD[ch][k] * r_op[k];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_ctl <= '0;
            r_s2_ctl <= '0;
        end else if (i_en) begin
            r_s1_ctl <= '{valid: i_valid, func: i_data.func};
            r_s2_ctl <= r_s1_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_op   <= n_op;
            r_prod <= n_prod;
        end
    end

    assign o_ctl  = r_s2_ctl;
    assign o_prod = r_prod;

endmodule

// ===== design/rycc_sum.sv =====
// ----------------------------------------------------------------------------
// rycc_sum
// per channel sum of the three products plus the rounding half
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rycc_sum #(
    parameter int COEF_FRAC_BITS = 16
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_en,
    input  rycc_pkg::t_ctl            i_ctl,
    input  logic signed [COEF_FRAC_BITS+3+rycc_pkg::OPW-1:0]
                                      i_prod [rycc_pkg::NCH][rycc_pkg::NCH],
    output rycc_pkg::t_ctl            o_ctl,
    output logic signed [COEF_FRAC_BITS+5+rycc_pkg::OPW-1:0]
                                      o_sum [rycc_pkg::NCH]
);

    localparam int PW = COEF_FRAC_BITS + 3 + rycc_pkg::OPW;
    localparam int SW = PW + 2;
    localparam logic signed [SW-1:0] HALF = SW'(longint'(1) << (COEF_FRAC_BITS - 1));

    rycc_pkg::t_ctl       r_ctl;
    logic signed [SW-1:0] r_sum [rycc_pkg::NCH];
    logic signed [SW-1:0] n_sum [rycc_pkg::NCH];

    always_comb begin
        for (int ch = 0; ch < rycc_pkg::NCH; ch++) begin
            n_sum[ch] = SW'(i_prod[ch][0]) + SW'(i_prod[ch][1])
                        + SW'(i_prod[ch][2]) + HALF;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else if (i_en) begin
            r_ctl <= i_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sum <= n_sum;
        end
    end

    assign o_ctl = r_ctl;
    assign o_sum = r_sum;

endmodule

// ===== design/rycc_fin.sv =====
// ----------------------------------------------------------------------------
// rycc_fin
// truncation toward zero, chroma offset, saturation and the output register
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rycc_fin #(
    parameter int COEF_FRAC_BITS = 16
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_en,
    input  rycc_pkg::t_ctl            i_ctl,
    input  logic signed [COEF_FRAC_BITS+5+rycc_pkg::OPW-1:0]
                                      i_sum [rycc_pkg::NCH],
    output logic                      o_valid,
    output rycc_pkg::t_pix_out        o_data
);

    localparam int SW = COEF_FRAC_BITS + 5 + rycc_pkg::OPW;
    localparam int TW = SW - COEF_FRAC_BITS;
    localparam int VW = TW + 1;
    localparam logic signed [SW-1:0] MASK = SW'((longint'(1) << COEF_FRAC_BITS) - 1);

    rycc_pkg::t_ctl       r_s4_ctl;
    rycc_pkg::t_ctl       r_s5_ctl;
    logic signed [TW-1:0] r_tr [rycc_pkg::NCH];
    logic signed [TW-1:0] n_tr [rycc_pkg::NCH];
    logic signed [SW-1:0] adj  [rycc_pkg::NCH];
    logic signed [VW-1:0] val  [rycc_pkg::NCH];
    logic signed [VW-1:0] hi   [rycc_pkg::NCH];
    logic [8:0]           sat  [rycc_pkg::NCH];
    logic [rycc_pkg::NCH-1:0] clip;
    rycc_pkg::t_pix_out   r_out;
    rycc_pkg::t_pix_out   n_out;

    // negative values get the mask added first so the shift rounds toward zero
    always_comb begin
        for (int ch = 0; ch < rycc_pkg::NCH; ch++) begin
            adj[ch]  = i_sum[ch][SW-1] ? MASK : '0;
            n_tr[ch] = TW'((i_sum[ch] + adj[ch]) >>> COEF_FRAC_BITS);
        end
    end

    always_comb begin
        for (int ch = 0; ch < rycc_pkg::NCH; ch++) begin
            if (r_s4_ctl.func == rycc_pkg::FUNC_RGB2YUV && ch != rycc_pkg::CH_0) begin
                val[ch] = VW'(r_tr[ch]) + VW'(rycc_pkg::CHROMA_OFS);
                hi[ch]  = VW'(rycc_pkg::SAT_HI_9);
            end else begin
                val[ch] = VW'(r_tr[ch]);
                hi[ch]  = VW'(rycc_pkg::SAT_HI_8);
            end
            priority if (val[ch] > hi[ch]) begin
                sat[ch]  = 9'(hi[ch]);
                clip[ch] = 1'b1;
            end else if (val[ch] < 0) begin
                sat[ch]  = '0;
                clip[ch] = 1'b1;
            end else begin
                sat[ch]  = 9'(val[ch]);
                clip[ch] = 1'b0;
            end
        end
        n_out.out0     = sat[rycc_pkg::CH_0][7:0];
        n_out.out1     = sat[rycc_pkg::CH_1];
        n_out.out2     = sat[rycc_pkg::CH_2];
        n_out.in_gamut = (r_s4_ctl.func == rycc_pkg::FUNC_RGB2YUV) || (clip == '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s4_ctl <= '0;
            r_s5_ctl <= '0;
        end else if (i_en) begin
            r_s4_ctl <= i_ctl;
            r_s5_ctl <= r_s4_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_tr  <= n_tr;
            r_out <= n_out;
        end
    end

    assign o_valid = r_s5_ctl.valid;
    assign o_data  = r_out;

`ifndef ASSERT_OFF
    a_fwd_gamut: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s5_ctl.valid && r_s5_ctl.func == rycc_pkg::FUNC_RGB2YUV) |-> r_out.in_gamut)
        else $error("forward transaction flagged out of gamut");

    a_inv_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s5_ctl.valid && r_s5_ctl.func == rycc_pkg::FUNC_YUV2RGB)
        |-> (r_out.out1[8] == 1'b0 && r_out.out2[8] == 1'b0))
        else $error("inverse transaction exceeds 255");

    a_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_en && r_s4_ctl.valid) |=> r_s5_ctl.valid)
        else $error("transaction lost between last two stages");
`endif

endmodule
